// ----- src/latency_histogram_percentile_assert.svh -----
// Assertion helpers for the latency histogram block.
// Each macro needs a signal named clock in scope; the first two also need reset.
`ifndef LATENCY_HISTOGRAM_PERCENTILE_ASSERT_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LHP_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lhp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LHP_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lhp: next-cycle check failed");

// Next-cycle implication that also holds while reset is applied.
`define LHP_ASSERT_ALWAYS(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("lhp: reset check failed");

`endif

// ----- src/lhp_pkg.sv -----
`default_nettype none

package lhp_pkg;

   localparam int NUM_BINS   = 400;
   localparam int BIN_WIDTH  = 5;
   localparam int COUNT_BITS = 24;

   localparam int FUNC_BITS  = 2;
   localparam int LAT_BITS   = 32;
   localparam int PERM_BITS  = 10;
   localparam int THR_BITS   = 11;
   localparam int PERM_FULL  = 1000;

   localparam int BIN_BITS   = $clog2(NUM_BINS);

   // Latencies at or above this value all land in the last bin.
   localparam int LAT_LIMIT  = NUM_BINS * BIN_WIDTH;
   localparam int LIM_BITS   = (LAT_LIMIT > 2) ? $clog2(LAT_LIMIT) : 1;

   // Reciprocal multiply for latency / BIN_WIDTH, exact below LAT_LIMIT.
   localparam int DIV_SHIFT   = LIM_BITS + 7;
   localparam int DIV_MULT    = ((2 ** DIV_SHIFT) + BIN_WIDTH - 1) / BIN_WIDTH;
   localparam int MULT_BITS   = DIV_SHIFT + 1;
   localparam int QPROD_BITS  = LIM_BITS + MULT_BITS;

   // Percentile arithmetic, scaled by PERM_FULL so no division is needed.
   localparam int PROD_BITS   = PERM_BITS + COUNT_BITS;
   localparam int SCALED_BITS = COUNT_BITS + PERM_BITS;
   localparam int ACC_BITS    = SCALED_BITS + BIN_BITS;

   localparam int BW_BITS     = $clog2(BIN_WIDTH + 1);
   localparam int THR_MUL_BITS = (BIN_BITS + BW_BITS > THR_BITS) ?
                                 (BIN_BITS + BW_BITS) : THR_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_RECORD = 2'd1,
      FUNC_QUERY  = 2'd2
   } lhp_func_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_WALK
   } lhp_state_type;

   typedef struct packed {
      lhp_func_type         func;
      logic [BIN_BITS-1:0]  bin;
      logic [PERM_BITS-1:0] perm;
   } lhp_op_type;

endpackage

`default_nettype wire

// ----- src/latency_histogram_percentile.sv -----
// Channel  Dir  Handshake              Fields
// req      in   req_valid / req_stall  func, latency_cycles, percentile_permille
// rsp      out  rsp_valid / rsp_stall  threshold_cycles, hist_empty
//
// Record items retire one per cycle through a read-modify-write on the bin memory,
// unless a clear sweep or a query walk holds the queue. A query walks the bins one
// per cycle on the memory read port; an empty histogram is answered without a walk.
// A clear item sweeps every bin of the memory to zero through its write port.
// After reset the same sweep runs; up to two items queue meanwhile.
// rsp_stall holds the result; a later query waits in the queue until it is taken.
`default_nettype none

module latency_histogram_percentile (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lhp_pkg::FUNC_BITS-1:0]  req_func,
   input  logic [lhp_pkg::LAT_BITS-1:0]   req_latency_cycles,
   input  logic [lhp_pkg::PERM_BITS-1:0]  req_percentile_permille,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lhp_pkg::THR_BITS-1:0]   rsp_threshold_cycles,
   output logic                           rsp_hist_empty
);
   import lhp_pkg::*;

   logic       queue_full;
   logic       push_valid;
   lhp_op_type push_data;
   logic       q_valid;
   lhp_op_type q_data;
   logic       q_pop;

   lhp_front u_front (
      .req_valid               (req_valid),
      .req_func                (req_func),
      .req_latency_cycles      (req_latency_cycles),
      .req_percentile_permille (req_percentile_permille),
      .req_stall               (req_stall),
      .queue_full              (queue_full),
      .push_valid              (push_valid),
      .push_data               (push_data)
   );

   lhp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop)
   );

   lhp_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_data               (q_data),
      .q_pop                (q_pop),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_threshold_cycles (rsp_threshold_cycles),
      .rsp_hist_empty       (rsp_hist_empty)
   );

endmodule

`default_nettype wire

// ----- src/lhp_front.sv -----
`default_nettype none

module lhp_front (
   input  logic                           req_valid,
   input  logic [lhp_pkg::FUNC_BITS-1:0]  req_func,
   input  logic [lhp_pkg::LAT_BITS-1:0]   req_latency_cycles,
   input  logic [lhp_pkg::PERM_BITS-1:0]  req_percentile_permille,
   output logic                           req_stall,
   input  logic                           queue_full,
   output logic                           push_valid,
   output lhp_pkg::lhp_op_type            push_data
);
   import lhp_pkg::*;

   logic [QPROD_BITS-1:0] quot_prod;
   logic [BIN_BITS-1:0]   bin;
   logic [PERM_BITS-1:0]  perm;
   logic                  known;

   assign quot_prod = QPROD_BITS'(req_latency_cycles[LIM_BITS-1:0]) * QPROD_BITS'(DIV_MULT);

   assign bin = (req_latency_cycles >= LAT_BITS'(LAT_LIMIT)) ? BIN_BITS'(NUM_BINS - 1)
                                                             : BIN_BITS'(quot_prod >> DIV_SHIFT);

   assign perm = (req_percentile_permille > PERM_BITS'(PERM_FULL)) ? PERM_BITS'(PERM_FULL)
                                                                   : req_percentile_permille;

   // The unused operation code is taken and dropped here.
   always_comb begin
      unique case (req_func)
         FUNC_CLEAR, FUNC_RECORD, FUNC_QUERY: known = 1'b1;
         default:                             known = 1'b0;
      endcase
   end

   assign req_stall       = queue_full;
   assign push_valid      = req_valid && !queue_full && known;
   assign push_data.func  = lhp_func_type'(req_func);
   assign push_data.bin   = bin;
   assign push_data.perm  = perm;

endmodule

`default_nettype wire

// ----- src/lhp_queue.sv -----
`default_nettype none

module lhp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  lhp_pkg::lhp_op_type push_data,
   output logic                queue_full,
   output logic                q_valid,
   output lhp_pkg::lhp_op_type q_data,
   input  logic                q_pop
);
   import lhp_pkg::*;

   lhp_op_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QCNT_BITS-1:0] count_in;
   logic                 do_push;
   logic                 do_pop;

   assign queue_full = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_data     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- src/lhp_back.sv -----
`default_nettype none

module lhp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  lhp_pkg::lhp_op_type           q_data,
   output logic                          q_pop,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [lhp_pkg::THR_BITS-1:0]  rsp_threshold_cycles,
   output logic                          rsp_hist_empty
);
   import lhp_pkg::*;

   logic [COUNT_BITS-1:0]   mem [NUM_BINS];
   logic [COUNT_BITS-1:0]   rd_data_ff;
   logic [BIN_BITS-1:0]     rd_addr;
   logic                    mem_we;
   logic [BIN_BITS-1:0]     mem_wa;
   logic [COUNT_BITS-1:0]   mem_wd;

   lhp_state_type           state_ff;
   lhp_state_type           state_in;
   logic [BIN_BITS-1:0]     clr_idx_ff;
   logic [BIN_BITS-1:0]     clr_idx_in;
   logic [COUNT_BITS-1:0]   total_ff;
   logic [COUNT_BITS-1:0]   total_in;

   logic                    rec1_valid_ff;
   logic [BIN_BITS-1:0]     rec1_bin_ff;
   logic                    wr_valid_ff;
   logic [BIN_BITS-1:0]     wr_bin_ff;
   logic [COUNT_BITS-1:0]   wr_val_ff;
   logic [COUNT_BITS-1:0]   rec_src;
   logic [COUNT_BITS-1:0]   rec_new;

   logic [PERM_BITS-1:0]    perm_ff;
   logic [PROD_BITS-1:0]    prod_ff;
   logic [BIN_BITS-1:0]     walk_idx_ff;
   logic                    iss_on_ff;
   logic                    s1_valid_ff;
   logic [BIN_BITS-1:0]     s1_idx_ff;
   logic                    s2_valid_ff;
   logic [BIN_BITS-1:0]     s2_idx_ff;
   logic [SCALED_BITS-1:0]  scaled_ff;
   logic [ACC_BITS-1:0]     acc_ff;
   logic [ACC_BITS-1:0]     acc_sum;
   logic [THR_MUL_BITS-1:0] thr_wide;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [THR_BITS-1:0]     thr_ff;
   logic                    empty_ff;

   logic                    rsp_free;
   logic                    pop_rec;
   logic                    pop_clear;
   logic                    pop_query;
   logic                    start_walk;
   logic                    walk_done;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Walk: the running sum is kept times PERM_FULL, so "sum > floor(P / 1000)"
   // becomes "1000 * sum > P" with P = permille * (total - 1).
   assign acc_sum   = acc_ff + ACC_BITS'(scaled_ff);
   assign walk_done = (state_ff == ST_WALK) && s2_valid_ff &&
                      ((acc_sum > ACC_BITS'(prod_ff)) ||
                       (s2_idx_ff == BIN_BITS'(NUM_BINS - 1)));
   assign thr_wide  = THR_MUL_BITS'(s2_idx_ff) * THR_MUL_BITS'(BIN_WIDTH);

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == BIN_BITS'(NUM_BINS - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (q_valid) begin
               unique case (q_data.func)
                  FUNC_RECORD: q_pop = 1'b1;
                  FUNC_CLEAR: begin
                     // Let a pending bin write land before the sweep owns the port.
                     if (!rec1_valid_ff) begin
                        q_pop    = 1'b1;
                        state_in = ST_CLEAR;
                     end
                  end
                  FUNC_QUERY: begin
                     if (rsp_free) begin
                        q_pop = 1'b1;
                        if (total_ff != '0) begin
                           state_in = ST_WALK;
                        end
                     end
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   assign pop_rec    = q_pop && (q_data.func == FUNC_RECORD);
   assign pop_clear  = q_pop && (q_data.func == FUNC_CLEAR);
   assign pop_query  = q_pop && (q_data.func == FUNC_QUERY);
   assign start_walk = pop_query && (total_ff != '0);

   // A write at the edge of the read is missed by the read, so it is forwarded.
   assign rec_src = (wr_valid_ff && (wr_bin_ff == rec1_bin_ff)) ? wr_val_ff : rd_data_ff;
   assign rec_new = (&rec_src) ? rec_src : rec_src + COUNT_BITS'(1);

   always_comb begin
      clr_idx_in = clr_idx_ff;
      if (state_ff == ST_CLEAR) begin
         clr_idx_in = (clr_idx_ff == BIN_BITS'(NUM_BINS - 1)) ? '0 : clr_idx_ff + 1'b1;
      end
      total_in = total_ff;
      if (pop_clear) begin
         total_in = '0;
      end else if (pop_rec) begin
         total_in = (&total_ff) ? total_ff : total_ff + COUNT_BITS'(1);
      end
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || walk_done ||
                     (pop_query && (total_ff == '0));
   end

   assign rd_addr = (state_ff == ST_WALK) ? walk_idx_ff : q_data.bin;
   assign mem_we  = (state_ff == ST_CLEAR) || rec1_valid_ff;
   assign mem_wa  = (state_ff == ST_CLEAR) ? clr_idx_ff : rec1_bin_ff;
   assign mem_wd  = (state_ff == ST_CLEAR) ? '0 : rec_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         total_ff      <= '0;
         rec1_valid_ff <= 1'b0;
         wr_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         iss_on_ff     <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         total_ff      <= total_in;
         rec1_valid_ff <= pop_rec;
         wr_valid_ff   <= rec1_valid_ff;
         rsp_valid_ff  <= rsp_valid_in;
         if (start_walk) begin
            iss_on_ff   <= 1'b1;
            s1_valid_ff <= 1'b0;
            s2_valid_ff <= 1'b0;
         end else if ((state_ff == ST_WALK) && !walk_done) begin
            if (iss_on_ff && (walk_idx_ff == BIN_BITS'(NUM_BINS - 1))) begin
               iss_on_ff <= 1'b0;
            end
            s1_valid_ff <= iss_on_ff;
            s2_valid_ff <= s1_valid_ff;
         end else begin
            iss_on_ff   <= 1'b0;
            s1_valid_ff <= 1'b0;
            s2_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec1_bin_ff <= q_data.bin;
      wr_bin_ff   <= rec1_bin_ff;
      wr_val_ff   <= rec_new;
      s1_idx_ff   <= walk_idx_ff;
      s2_idx_ff   <= s1_idx_ff;
      scaled_ff   <= SCALED_BITS'(rd_data_ff) * SCALED_BITS'(PERM_FULL);
      prod_ff     <= PROD_BITS'(perm_ff) * PROD_BITS'(total_ff - COUNT_BITS'(1));
      if (start_walk) begin
         perm_ff     <= q_data.perm;
         walk_idx_ff <= '0;
         acc_ff      <= '0;
      end else begin
         if (iss_on_ff) begin
            walk_idx_ff <= walk_idx_ff + 1'b1;
         end
         if (s2_valid_ff) begin
            acc_ff <= acc_sum;
         end
      end
      if (walk_done) begin
         thr_ff   <= thr_wide[THR_BITS-1:0];
         empty_ff <= 1'b0;
      end else if (pop_query && (total_ff == '0)) begin
         thr_ff   <= '0;
         empty_ff <= 1'b1;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_threshold_cycles = thr_ff;
   assign rsp_hist_empty       = empty_ff;

endmodule

`default_nettype wire

// ----- src/lhp_checker.sv -----
`default_nettype none
`include "latency_histogram_percentile_assert.svh"

module lhp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [lhp_pkg::THR_BITS-1:0]  rsp_threshold_cycles,
   input logic                          rsp_hist_empty
);

   // A result is never lost while the receiver stalls.
   `LHP_ASSERT_NEXT(rsp_hold_a, rsp_valid && rsp_stall, rsp_valid)

   // A stalled result keeps its payload.
   `LHP_ASSERT_NEXT(rsp_stable_a, rsp_valid && rsp_stall,
                    $stable(rsp_threshold_cycles) && $stable(rsp_hist_empty))

   // No result can be pending right after reset.
   `LHP_ASSERT_ALWAYS(rsp_reset_a, reset, !rsp_valid)

   // An empty histogram always answers a zero threshold.
   `LHP_ASSERT_IMPL(rsp_empty_a, rsp_valid && rsp_hist_empty, rsp_threshold_cycles == '0)

endmodule

bind latency_histogram_percentile lhp_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_threshold_cycles (rsp_threshold_cycles),
   .rsp_hist_empty       (rsp_hist_empty)
);

`default_nettype wire

// ----- bench/latency_histogram_percentile_tb.sv -----
`timescale 1ns / 100ps

module latency_histogram_percentile_tb;
   import lhp_pkg::*;

   localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [THR_BITS-1:0]  LAST_EDGE   = THR_BITS'((NUM_BINS - 1) * BIN_WIDTH);
   localparam int RANDOM_ITEMS = 1800;
   localparam int STALL_LIMIT  = 20 * (NUM_BINS + 8);
   localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;

   typedef struct packed {
      logic [FUNC_BITS-1:0] func;
      logic [LAT_BITS-1:0]  lat;
      logic [PERM_BITS-1:0] perm;
      logic                 answer_known;
      logic [THR_BITS-1:0]  thr;
      logic                 empty;
   } stim_row_type;

   typedef struct packed {
      logic [THR_BITS-1:0] thr;
      logic                empty;
   } percentile_answer_type;

   // Answers marked known are read straight off the behavior; the rest are predicted.
   localparam stim_row_type DIRECTED_ROWS [26] = '{
      '{FUNC_QUERY,  32'd0,          10'd500,  1'b1, 11'd0, 1'b1},
      '{FUNC_UNUSED, 32'hFFFF_FFFF,  10'h3FF,  1'b0, 11'd0, 1'b0},
      '{FUNC_QUERY,  32'hFFFF_FFFF,  10'h3FF,  1'b1, 11'd0, 1'b1},
      '{FUNC_CLEAR,  32'd0,          10'd0,    1'b0, 11'd0, 1'b0},
      '{FUNC_RECORD, 32'd0,          10'h3FF,  1'b0, 11'd0, 1'b0},
      '{FUNC_QUERY,  32'd0,          10'd0,    1'b1, 11'd0, 1'b0},
      '{FUNC_QUERY,  32'd0,          10'd1000, 1'b1, 11'd0, 1'b0},
      '{FUNC_RECORD, 32'hFFFF_FFFF,  10'd0,    1'b0, 11'd0, 1'b0},
      '{FUNC_QUERY,  32'd0,          10'd1000, 1'b1, LAST_EDGE, 1'b0},
      '{FUNC_QUERY,  32'd0,          10'd1023, 1'b1, LAST_EDGE, 1'b0},
      '{FUNC_QUERY,  32'd0,          10'd0,    1'b1, 11'd0, 1'b0},
      '{FUNC_QUERY,  32'd0,          10'd999,  1'b0, 11'd0, 1'b0},
      '{FUNC_RECORD, LAT_LIMIT - 1,  10'd0,    1'b0, 11'd0, 1'b0},
      '{FUNC_RECORD, LAT_LIMIT,      10'd0,    1'b0, 11'd0, 1'b0},
      '{FUNC_RECORD, BIN_WIDTH - 1,  10'd0,    1'b0, 11'd0, 1'b0},
      '{FUNC_RECORD, BIN_WIDTH,      10'd0,    1'b0, 11'd0, 1'b0},
      '{FUNC_RECORD, 32'hAAAA_AAAA,  10'h2AA,  1'b0, 11'd0, 1'b0},
      '{FUNC_RECORD, 32'h5555_5555,  10'h155,  1'b0, 11'd0, 1'b0},
      '{FUNC_QUERY,  32'd0,          10'd500,  1'b0, 11'd0, 1'b0},
      '{FUNC_QUERY,  32'hFFFF_FFFF,  10'd1,    1'b0, 11'd0, 1'b0},
      '{FUNC_CLEAR,  32'hFFFF_FFFF,  10'h3FF,  1'b0, 11'd0, 1'b0},
      '{FUNC_QUERY,  32'd0,          10'd750,  1'b1, 11'd0, 1'b1},
      '{FUNC_RECORD, LAT_LIMIT - BIN_WIDTH - 1, 10'd0, 1'b0, 11'd0, 1'b0},
      '{FUNC_RECORD, LAT_LIMIT - BIN_WIDTH,     10'd0, 1'b0, 11'd0, 1'b0},
      '{FUNC_QUERY,  32'd0,          10'd0,    1'b0, 11'd0, 1'b0},
      '{FUNC_QUERY,  32'd0,          10'd1000, 1'b1, LAST_EDGE, 1'b0}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [FUNC_BITS-1:0] req_func;
   logic [LAT_BITS-1:0]  req_latency_cycles;
   logic [PERM_BITS-1:0] req_percentile_permille;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [THR_BITS-1:0]  rsp_threshold_cycles;
   logic                 rsp_hist_empty;

   // Known answer of the item on the request port, held alongside its payload.
   logic                 item_answer_known;
   logic [THR_BITS-1:0]  item_thr;
   logic                 item_empty;

   logic [COUNT_BITS-1:0] hist_bins [NUM_BINS];
   logic [COUNT_BITS-1:0] hist_total;
   percentile_answer_type percentile_answers [$];

   int send_idle_pct  = 23;
   int recv_stall_pct = 72;
   int error_count    = 0;
   int n_records      = 0;
   int n_queries      = 0;
   int n_clears       = 0;
   int n_unused       = 0;
   int n_results      = 0;
   int n_empty        = 0;
   int n_last_bin     = 0;

   latency_histogram_percentile dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_func                (req_func),
      .req_latency_cycles      (req_latency_cycles),
      .req_percentile_permille (req_percentile_permille),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_threshold_cycles    (rsp_threshold_cycles),
      .rsp_hist_empty          (rsp_hist_empty)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_histogram_model();
      foreach (hist_bins[i]) hist_bins[i] = '0;
      hist_total = '0;
   endfunction

   function automatic void record_latency(input logic [LAT_BITS-1:0] lat);
      logic [LAT_BITS-1:0] quot;
      logic [BIN_BITS-1:0] bin;
      quot = lat / BIN_WIDTH;
      bin  = (quot > LAT_BITS'(NUM_BINS - 1)) ? BIN_BITS'(NUM_BINS - 1) : quot[BIN_BITS-1:0];
      if (hist_bins[bin] != COUNT_SAT) hist_bins[bin] = hist_bins[bin] + 1'b1;
      if (hist_total != COUNT_SAT) hist_total = hist_total + 1'b1;
   endfunction

   function automatic percentile_answer_type predict_percentile(input logic [PERM_BITS-1:0] perm);
      percentile_answer_type answer;
      longint unsigned p;
      longint unsigned target;
      longint unsigned running;
      bit found;
      answer.thr   = LAST_EDGE;
      answer.empty = 1'b0;
      if (hist_total == '0) begin
         answer.thr   = '0;
         answer.empty = 1'b1;
      end else begin
         p = (perm > PERM_BITS'(PERM_FULL)) ? 64'(PERM_FULL) : 64'(perm);
         target = (p * (64'(hist_total) - 64'd1)) / 64'(PERM_FULL);
         running = 0;
         found = 1'b0;
         // Saturated bins can leave the sum short of target; the last edge stands then.
         for (int i = 0; i < NUM_BINS; i++) begin
            if (!found) begin
               running += 64'(hist_bins[i]);
               if (running > target) begin
                  answer.thr = THR_BITS'(i * BIN_WIDTH);
                  found = 1'b1;
               end
            end
         end
      end
      return answer;
   endfunction

   function automatic logic [LAT_BITS-1:0] pick_latency(input int center);
      logic [LAT_BITS-1:0] lat;
      case ($urandom_range(9))
         0, 1, 2: lat = $urandom_range(LAT_LIMIT + 100);
         3, 4:    lat = center + $urandom_range(3 * BIN_WIDTH);
         5:       lat = $urandom_range(NUM_BINS - 1) * BIN_WIDTH
                        + ($urandom_range(1) ? BIN_WIDTH - 1 : 0);
         6:       lat = LAT_LIMIT - 1 + $urandom_range(1);
         default: lat = $urandom;
      endcase
      return lat;
   endfunction

   function automatic logic [PERM_BITS-1:0] pick_permille();
      logic [PERM_BITS-1:0] perm;
      case ($urandom_range(9))
         0:       perm = '0;
         1:       perm = PERM_BITS'(PERM_FULL);
         2:       perm = PERM_BITS'($urandom_range(1023, PERM_FULL + 1));
         default: perm = PERM_BITS'($urandom_range(PERM_FULL));
      endcase
      return perm;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: result %0d: %s", $realtime, n_results, msg);
      error_count++;
   endtask

   // Presents one item and returns at the edge where it is taken.
   task automatic send_item(input stim_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_func                <= row.func;
      req_latency_cycles      <= row.lat;
      req_percentile_permille <= row.perm;
      item_answer_known       <= row.answer_known;
      item_thr                <= row.thr;
      item_empty              <= row.empty;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic send_op(input logic [FUNC_BITS-1:0] func, input logic [LAT_BITS-1:0] lat,
                          input logic [PERM_BITS-1:0] perm);
      stim_row_type row;
      row = '{func, lat, perm, 1'b0, 11'd0, 1'b0};
      send_item(row);
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Requests are handled before results so a same-edge answer would still find its entry.
   always @(posedge clock) begin : watch_channels
      percentile_answer_type want;
      if (!reset) begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            case (req_func)
               FUNC_CLEAR: begin
                  clear_histogram_model();
                  n_clears++;
               end
               FUNC_RECORD: begin
                  record_latency(req_latency_cycles);
                  n_records++;
               end
               FUNC_QUERY: begin
                  want = predict_percentile(req_percentile_permille);
                  if (item_answer_known) want = '{item_thr, item_empty};
                  percentile_answers.push_back(want);
                  n_queries++;
               end
               default: n_unused++;
            endcase
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (percentile_answers.size() == 0) begin
               report_mismatch($sformatf("unexpected result, threshold %0d empty %0b",
                                         rsp_threshold_cycles, rsp_hist_empty));
            end else begin
               want = percentile_answers.pop_front();
               if (rsp_threshold_cycles !== want.thr)
                  report_mismatch($sformatf("threshold_cycles %0d, expected %0d",
                                            rsp_threshold_cycles, want.thr));
               if (rsp_hist_empty !== want.empty)
                  report_mismatch($sformatf("hist_empty %0b, expected %0b",
                                            rsp_hist_empty, want.empty));
               if (want.empty) n_empty++;
               if (want.thr == LAST_EDGE) n_last_bin++;
            end
            n_results++;
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("ERROR: no item moved for %0d cycles", STALL_LIMIT);
      $display("latency_histogram_percentile_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      int sent;
      int burst;
      int center;
      reset                   = 1'b1;
      req_valid               = 1'b0;
      req_func                = FUNC_CLEAR;
      req_latency_cycles      = '0;
      req_percentile_permille = '0;
      item_answer_known       = 1'b0;
      item_thr                = '0;
      item_empty              = 1'b0;
      clear_histogram_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) send_item(DIRECTED_ROWS[i]);

      // Episodes: rare clear, maybe a query, record burst, a few queries, rare unused code.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case (sent * 3 / RANDOM_ITEMS)
            0: begin
               send_idle_pct  = 23;
               recv_stall_pct = 72;
            end
            1: begin
               send_idle_pct  = 72;
               recv_stall_pct = 23;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         if ($urandom_range(11) == 0) begin
            send_op(FUNC_CLEAR, $urandom, PERM_BITS'($urandom));
            sent++;
            if ($urandom_range(2) == 0) begin
               send_op(FUNC_QUERY, $urandom, pick_permille());
               sent++;
            end
         end
         burst  = $urandom_range(30, 1);
         center = $urandom_range(LAT_LIMIT - 1);
         repeat (burst) begin
            send_op(FUNC_RECORD, pick_latency(center), PERM_BITS'($urandom));
            sent++;
         end
         repeat ($urandom_range(3, 1)) begin
            send_op(FUNC_QUERY, $urandom, pick_permille());
            sent++;
         end
         if ($urandom_range(19) == 0) send_op(FUNC_UNUSED, $urandom, PERM_BITS'($urandom));
      end
      req_valid <= 1'b0;

      while (percentile_answers.size() != 0) @(posedge clock);
      repeat (NUM_BINS + 8) @(posedge clock);

      $display("Run covered %0d records, %0d clears, %0d unused codes and %0d queries.",
               n_records, n_clears, n_unused, n_queries);
      $display("Checked %0d results: %0d on an empty histogram, %0d at the last bin edge.",
               n_results, n_empty, n_last_bin);
      if (error_count == 0) begin
         $display("latency_histogram_percentile_tb: PASS");
      end else begin
         $display("latency_histogram_percentile_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/lhp_pkg.sv
src/lhp_front.sv
src/lhp_queue.sv
src/lhp_back.sv
src/latency_histogram_percentile.sv
src/lhp_checker.sv
bench/latency_histogram_percentile_tb.sv
